[hdl/spectrum_bar_level_with_decay_assert.svh]
// Assertion macros shared by the spectrum bar level RTL.
`ifndef SPECTRUM_BAR_LEVEL_WITH_DECAY_ASSERT_SVH
`define SPECTRUM_BAR_LEVEL_WITH_DECAY_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SBL_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define SBL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/sbl_pkg.sv]
// Types, constants and helper functions for the spectrum bar level block.
package sbl_pkg;

   localparam int SAMPLE_W      = 8;
   localparam int LEVEL_W       = 3;
   localparam int SLOT_OUT_W    = 4;
   localparam int ROW_W         = 8;
   localparam int COL_W         = 8;
   localparam int NUM_THRESH    = 7;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 8;
   localparam int SLOTS_DEFAULT = 16;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

   typedef logic [SAMPLE_W-1:0] thr_array_type [0:NUM_THRESH-1];
   typedef logic [ROW_W-1:0] row_table_type [0:(1 << LEVEL_W)-1];

   localparam thr_array_type THRESH_RESET = '{
      8'd30, 8'd35, 8'd43, 8'd55, 8'd73, 8'd101, 8'd150
   };

   // Bits left dark for each level; the lit bar is the complement.
   localparam row_table_type ROW_DARK = '{
      8'd127, 8'd63, 8'd31, 8'd15, 8'd7, 8'd3, 8'd1, 8'd0
   };

   typedef struct packed {
      logic                  en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      logic [LEVEL_W-1:0]    level;
      logic                  right_side;
   } level_out_type;

   function automatic logic [ROW_W-1:0] row_pattern(input logic [LEVEL_W-1:0] lvl);
      return ~ROW_DARK[lvl];
   endfunction

   function automatic logic [COL_W-1:0] column_select(input logic [2:0] col);
      return COL_W'(1) << col;
   endfunction

endpackage

[hdl/sbl_quant.sv]
// Threshold registers and the log-scale quantizer.
module sbl_quant (
   input  logic                          clock,
   input  logic                          reset,
   input  sbl_pkg::csr_write_type        csr_write,
   input  logic [sbl_pkg::SAMPLE_W-1:0]  sample,
   output logic [sbl_pkg::LEVEL_W-1:0]   fresh_level
);
   import sbl_pkg::*;

   thr_array_type thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_write.en && (csr_write.index < CSR_IDX_W'(NUM_THRESH))) begin
         thresh_ff[csr_write.index] <= csr_write.data;
      end
   end

   // The lowest index whose bound covers the sample wins, so scan from the top down.
   always_comb begin
      fresh_level = LEVEL_MAX;
      for (int i = NUM_THRESH - 1; i >= 0; i--) begin
         if (thresh_ff[i] >= sample) begin
            fresh_level = LEVEL_W'(i);
         end
      end
   end

endmodule

[hdl/sbl_level.sv]
// Slot counter, held-level memory and the decay rule.
`include "spectrum_bar_level_with_decay_assert.svh"

module sbl_level #(
   parameter int SLOTS = sbl_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [sbl_pkg::LEVEL_W-1:0]  fresh_level,
   output sbl_pkg::level_out_type       level_out
);
   import sbl_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int HALF   = SLOTS / 2;
   localparam logic [SLOT_W-1:0] SKIP_LOW  = SLOT_W'(HALF - 1);
   localparam logic [SLOT_W-1:0] SKIP_HIGH = SLOT_W'(SLOTS - 1);
   localparam logic [SLOT_W-1:0] HALF_SLOT = SLOT_W'(HALF);
   localparam logic [SLOT_W:0]   SLOT_END  = (SLOT_W + 1)'(SLOTS);

   logic [SLOT_W-1:0]  cnt_ff;
   logic [SLOT_W-1:0]  cnt_in;
   logic [SLOT_W:0]    step_one;
   logic [SLOT_W:0]    step_two;
   logic [SLOTS-1:0]   valid_ff;
   logic [LEVEL_W-1:0] held_mem [0:SLOTS-1];
   logic [LEVEL_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic [LEVEL_W-1:0] held_cur;
   logic [LEVEL_W-1:0] new_level;

   // The last slot of each half is never shown.
   always_comb begin
      step_one = {1'b0, cnt_ff} + (SLOT_W + 1)'(1);
      if ((step_one == {1'b0, SKIP_LOW}) || (step_one == {1'b0, SKIP_HIGH})) begin
         step_two = step_one + (SLOT_W + 1)'(1);
      end else begin
         step_two = step_one;
      end
      cnt_in = (step_two >= SLOT_END) ? '0 : step_two[SLOT_W-1:0];
   end

   // The next slot always differs from the current one, so its entry is read
   // ahead while the current one is written.
   always_ff @(posedge clock) begin
      if (advance) begin
         held_mem[cnt_ff] <= new_level;
         rd_data_ff       <= held_mem[cnt_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else if (advance) begin
         cnt_ff           <= cnt_in;
         valid_ff[cnt_ff] <= 1'b1;
         rd_valid_ff      <= valid_ff[cnt_in];
      end
   end

   // An entry never written since reset reads as zero.
   assign held_cur  = rd_valid_ff ? rd_data_ff : '0;
   assign new_level = (held_cur > fresh_level) ? (held_cur - LEVEL_W'(1)) : fresh_level;

   assign level_out.slot       = SLOT_OUT_W'(cnt_ff);
   assign level_out.level      = new_level;
   assign level_out.right_side = (cnt_ff >= HALF_SLOT);

   `SBL_ASSERT_ALWAYS(a_slot_in_use, (cnt_ff != SKIP_LOW) && (cnt_ff != SKIP_HIGH), "slot counter on an unused slot")
   `SBL_ASSERT_NEXT(a_slot_moves, advance, cnt_ff != $past(cnt_ff), "slot counter did not move")
   `SBL_ASSERT_ALWAYS(a_decay_step, (held_cur == '0) || (new_level >= (held_cur - LEVEL_W'(1))), "level fell by more than one")

endmodule

[hdl/spectrum_bar_level_with_decay.sv]
// Top level of the spectrum bar level meter with per-slot decay.
//
// Each request word carries one 8-bit band amplitude on req_sample. The block
// quantizes it against seven threshold registers to a level of 0 to 7, applies
// the decay rule to the level held for the current display slot and returns
// one response word: slot, smoothed level, row pattern, column select and the
// channel half. Slots run 0 to SLOTS-1, skipping the last slot of each half.
// rsp_valid rises once an accepted request has passed from the input register
// through quantizer and decay logic into the output register; one word is
// taken every cycle while the output is not stalled, limited by the single
// pass through quantizer and decay logic between the two registers.
// When rsp_stall is high with a response waiting, one further request is held
// in the input register, after which req_stall rises until the response leaves.
// Reset (synchronous) empties both registers, makes every held level read as
// zero, returns the slot counter to zero and loads the default thresholds.
// Thresholds are written through csr_wr_en, csr_index and csr_wr_data;
// indexes past the last threshold are ignored.
`include "spectrum_bar_level_with_decay_assert.svh"

module spectrum_bar_level_with_decay #(
   parameter int SLOTS = sbl_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sbl_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sbl_pkg::SLOT_OUT_W-1:0]  rsp_slot,
   output logic [sbl_pkg::LEVEL_W-1:0]     rsp_level,
   output logic [sbl_pkg::ROW_W-1:0]       rsp_row_bits,
   output logic [sbl_pkg::COL_W-1:0]       rsp_column_bits,
   output logic                            rsp_right_side,
   input  logic                            csr_wr_en,
   input  logic [sbl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sbl_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import sbl_pkg::*;

   logic                  s1_valid_ff;
   logic [SAMPLE_W-1:0]   s1_sample_ff;
   logic                  rsp_valid_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [LEVEL_W-1:0]    rsp_level_ff;
   logic [ROW_W-1:0]      rsp_row_ff;
   logic [COL_W-1:0]      rsp_col_ff;
   logic                  rsp_right_ff;
   logic                  advance;
   logic                  accept;
   logic [LEVEL_W-1:0]    fresh_level;
   csr_write_type         csr_write;
   level_out_type         level_out;

   assign csr_write.en    = csr_wr_en;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_wr_data;

   // The input word moves on whenever the output register is empty or being emptied.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   sbl_quant u_quant (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .sample      (s1_sample_ff),
      .fresh_level (fresh_level)
   );

   sbl_level #(
      .SLOTS (SLOTS)
   ) u_level (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .fresh_level (fresh_level),
      .level_out   (level_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_slot_ff  <= level_out.slot;
         rsp_level_ff <= level_out.level;
         rsp_row_ff   <= row_pattern(level_out.level);
         rsp_col_ff   <= column_select(level_out.slot[2:0]);
         rsp_right_ff <= level_out.right_side;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_row_bits    = rsp_row_ff;
   assign rsp_column_bits = rsp_col_ff;
   assign rsp_right_side  = rsp_right_ff;

   `SBL_ASSERT_NEXT(a_word_reaches_output, advance, rsp_valid_ff, "advanced word missing at output")
   `SBL_ASSERT_NEXT(a_held_word_kept, req_stall, s1_valid_ff && (s1_sample_ff == $past(s1_sample_ff)), "held input word lost")
   `SBL_ASSERT_NEXT(a_rsp_word_kept, rsp_valid_ff && rsp_stall, rsp_valid_ff, "stalled word dropped")

endmodule
